[sv/rwlm_pkg.sv]
// Shared types and constants for the reader/writer lock manager.
`timescale 1ns / 1ps

package rwlm_pkg;

    // Counter and identity limits
    localparam int COUNT_MAX      = 255;
    localparam int THREAD_ID_MAX  = 255;
    localparam int WAITERS_MAX    = 255;
    localparam int READER_Q_LIMIT = (COUNT_MAX < WAITERS_MAX) ? COUNT_MAX : WAITERS_MAX;

    // Field widths
    localparam int OP_W      = 2;
    localparam int TID_W     = 8;
    localparam int OUTCOME_W = 3;
    localparam int WAITERS_W = 8;
    localparam int COUNT_W   = 9;

    // Packed bus widths
    localparam int S_DATA_W = 16;  // thread_id, may_wait, woken_retry = 10 bits
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 24;  // wake_writer, wake_readers, active_count = 18 bits
    localparam int M_USER_W = OUTCOME_W;

    // Request kinds
    typedef enum logic [OP_W-1:0] {
        OP_ACQ_EXCL   = 2'd0,
        OP_ACQ_SHARED = 2'd1,
        OP_RELEASE    = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    // Result codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_GRANTED  = 3'd0,
        OUT_REFUSED  = 3'd1,
        OUT_QUEUED   = 3'd2,
        OUT_RELEASED = 3'd3,
        OUT_IGNORED  = 3'd4
    } outcome_t;

    typedef logic signed [COUNT_W-1:0] count_t;

endpackage

[sv/reader_writer_lock_manager_core.sv]
// Reader/writer lock manager core: request register, decision logic, result register.
`timescale 1ns / 1ps

// One request enters per cycle; once accepted it passes the request register
// and then the result register, which holds its result; the lock state is
// updated in the same cycle the result is registered, so the next request
// in the request register always sees the effect of the one before it. The
// sustained rate is one request per clock, limited only by back-pressure on
// the result side. The request kind travels on s_tuser, the result code on
// m_tuser. A release wakes one waiting writer first, otherwise all waiting
// readers, who are counted as holders at once; their retries, flagged with
// woken_retry, are granted without counting again. The releaser's identity
// is not checked.
module reader_writer_lock_manager_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rwlm_pkg::S_DATA_W-1:0] s_tdata,  // thread_id[7:0], may_wait[8], woken_retry[9]
    input  logic [rwlm_pkg::S_USER_W-1:0] s_tuser,  // op[1:0]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rwlm_pkg::M_DATA_W-1:0] m_tdata,  // wake_writer[0], wake_readers[8:1],
                                                    // active_count[17:9]
    output logic [rwlm_pkg::M_USER_W-1:0] m_tuser   // outcome[2:0]
);

    // Request register
    logic                             in_valid_reg;
    rwlm_pkg::op_t                    op_reg;
    logic [rwlm_pkg::TID_W-1:0]       tid_reg;
    logic                             may_wait_reg;
    logic                             woken_reg;

    // Result register
    logic                             out_valid_reg;
    rwlm_pkg::outcome_t               outcome_reg;
    logic                             wake_w_reg;
    logic [rwlm_pkg::WAITERS_W-1:0]   wake_r_reg;
    rwlm_pkg::count_t                 count_out_reg;

    // Lock state
    rwlm_pkg::count_t                 count_reg;
    logic [rwlm_pkg::TID_W-1:0]       owner_reg;
    logic [rwlm_pkg::WAITERS_W-1:0]   wwait_reg;
    logic [rwlm_pkg::WAITERS_W-1:0]   rwait_reg;

    // Next values
    rwlm_pkg::count_t                 count_next;
    logic [rwlm_pkg::TID_W-1:0]       owner_next;
    logic [rwlm_pkg::WAITERS_W-1:0]   wwait_next;
    logic [rwlm_pkg::WAITERS_W-1:0]   rwait_next;
    rwlm_pkg::outcome_t               outcome_next;
    logic                             wake_w_next;
    logic [rwlm_pkg::WAITERS_W-1:0]   wake_r_next;

    logic advance;
    logic tid_bad;
    logic is_owner;
    logic writer_at_max;
    logic reader_at_max;
    logic wwait_full;
    logic rwait_room;
    rwlm_pkg::count_t count_dec;
    rwlm_pkg::count_t count_inc;

    // Handshake: the request register moves on whenever the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = outcome_reg;
    assign m_tdata  = {6'd0, count_out_reg, wake_r_reg, wake_w_reg};

    // Compares shared by the decision logic
    assign tid_bad       = 32'(tid_reg) > 32'(rwlm_pkg::THREAD_ID_MAX);
    assign is_owner      = owner_reg == tid_reg;
    assign writer_at_max = 32'(signed'(count_reg)) <= -rwlm_pkg::COUNT_MAX;
    assign reader_at_max = 32'(signed'(count_reg)) >= rwlm_pkg::COUNT_MAX;
    assign wwait_full    = 32'(wwait_reg) >= rwlm_pkg::WAITERS_MAX;
    assign rwait_room    = 32'(rwait_reg) < rwlm_pkg::READER_Q_LIMIT;
    assign count_dec     = count_reg - rwlm_pkg::count_t'(1);
    assign count_inc     = count_reg + rwlm_pkg::count_t'(1);

    // Decision logic for one request
    always_comb
    begin
        count_next   = count_reg;
        owner_next   = owner_reg;
        wwait_next   = wwait_reg;
        rwait_next   = rwait_reg;
        outcome_next = rwlm_pkg::OUT_REFUSED;
        wake_w_next  = 1'b0;
        wake_r_next  = '0;
        unique case (op_reg)
            rwlm_pkg::OP_ACQ_EXCL:
            begin
                if (tid_bad)
                begin
                    outcome_next = rwlm_pkg::OUT_REFUSED;
                end
                else if (count_reg == '0)
                begin
                    count_next   = -rwlm_pkg::count_t'(1);
                    owner_next   = tid_reg;
                    outcome_next = rwlm_pkg::OUT_GRANTED;
                end
                else if (count_reg < 0 && is_owner)
                begin
                    if (!writer_at_max)
                    begin
                        count_next   = count_dec;
                        outcome_next = rwlm_pkg::OUT_GRANTED;
                    end
                end
                else if (may_wait_reg && !wwait_full)
                begin
                    wwait_next   = wwait_reg + 1'b1;
                    outcome_next = rwlm_pkg::OUT_QUEUED;
                end
            end
            rwlm_pkg::OP_ACQ_SHARED:
            begin
                if (tid_bad)
                begin
                    outcome_next = rwlm_pkg::OUT_REFUSED;
                end
                else if (count_reg < 0)
                begin
                    // writer holds: owner re-enters, others queue or are refused
                    if (is_owner)
                    begin
                        if (!writer_at_max)
                        begin
                            count_next   = count_dec;
                            outcome_next = rwlm_pkg::OUT_GRANTED;
                        end
                    end
                    else if (may_wait_reg && rwait_room)
                    begin
                        rwait_next   = rwait_reg + 1'b1;
                        outcome_next = rwlm_pkg::OUT_QUEUED;
                    end
                end
                else if (woken_reg)
                begin
                    outcome_next = rwlm_pkg::OUT_GRANTED;
                end
                else if (!reader_at_max)
                begin
                    count_next   = count_inc;
                    outcome_next = rwlm_pkg::OUT_GRANTED;
                end
            end
            rwlm_pkg::OP_RELEASE:
            begin
                if (count_reg > 0)
                begin
                    count_next   = count_dec;
                    outcome_next = rwlm_pkg::OUT_RELEASED;
                    if (count_dec == '0 && wwait_reg != '0)
                    begin
                        wwait_next  = wwait_reg - 1'b1;
                        wake_w_next = 1'b1;
                    end
                end
                else if (count_reg < 0)
                begin
                    count_next   = count_inc;
                    outcome_next = rwlm_pkg::OUT_RELEASED;
                    if (count_inc == '0)
                    begin
                        // lock freed: one writer first, else every waiting reader
                        owner_next = '0;
                        if (wwait_reg != '0)
                        begin
                            wwait_next  = wwait_reg - 1'b1;
                            wake_w_next = 1'b1;
                        end
                        else if (rwait_reg != '0)
                        begin
                            wake_r_next = rwait_reg;
                            count_next  = rwlm_pkg::count_t'({1'b0, rwait_reg});
                            rwait_next  = '0;
                        end
                    end
                end
                else
                begin
                    outcome_next = rwlm_pkg::OUT_IGNORED;
                end
            end
            default:
            begin
                outcome_next = rwlm_pkg::OUT_REFUSED;
            end
        endcase
    end

    // Control and lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            owner_reg     <= '0;
            wwait_reg     <= '0;
            rwait_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                owner_reg     <= owner_next;
                wwait_reg     <= wwait_next;
                rwait_reg     <= rwait_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg       <= rwlm_pkg::op_t'(s_tuser[rwlm_pkg::OP_W-1:0]);
            tid_reg      <= s_tdata[7:0];
            may_wait_reg <= s_tdata[8];
            woken_reg    <= s_tdata[9];
        end
        if (advance)
        begin
            outcome_reg   <= outcome_next;
            wake_w_reg    <= wake_w_next;
            wake_r_reg    <= wake_r_next;
            count_out_reg <= count_next;
        end
    end

endmodule

[tb/rwlm_result_monitor.sv]
// Result monitor for the lock manager: predicts each result and compares it.
`timescale 1ns / 1ps

module rwlm_result_monitor
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rwlm_pkg::S_DATA_W-1:0] s_tdata,  // thread_id[7:0], may_wait[8], woken_retry[9]
    input  logic [rwlm_pkg::S_USER_W-1:0] s_tuser,  // op[1:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rwlm_pkg::M_DATA_W-1:0] m_tdata,  // wake_writer[0], wake_readers[8:1],
                                                    // active_count[17:9]
    input  logic [rwlm_pkg::M_USER_W-1:0] m_tuser,  // outcome[2:0]
    output int                            mismatches,
    output int                            results_pending
);

    localparam int REPORT_LIMIT = 50;

    typedef struct packed {
        rwlm_pkg::outcome_t                 outcome;
        logic                               wake_writer;
        logic [rwlm_pkg::WAITERS_W-1:0]     wake_readers;
        rwlm_pkg::count_t                   active;
    } lock_result_t;

    // Shadow of the lock state
    int                             lock_count;
    logic [rwlm_pkg::TID_W-1:0]     owner_id;
    int                             writers_waiting;
    int                             readers_waiting;

    lock_result_t       results_due[$];
    int                 fail_total;

    // Owner re-entry: one level deeper unless the writer depth is at its limit
    function automatic rwlm_pkg::outcome_t deepen_writer_depth();
        if (lock_count <= -rwlm_pkg::COUNT_MAX)
            return rwlm_pkg::OUT_REFUSED;
        lock_count--;
        return rwlm_pkg::OUT_GRANTED;
    endfunction

    // Lock state update for one request, returning the result it causes
    function automatic lock_result_t predict_lock_step(rwlm_pkg::op_t op,
                                                       logic [rwlm_pkg::TID_W-1:0] tid,
                                                       logic may_wait, logic woken);
        lock_result_t r;
        r.outcome      = rwlm_pkg::OUT_REFUSED;
        r.wake_writer  = 1'b0;
        r.wake_readers = '0;
        case (op)
            rwlm_pkg::OP_ACQ_EXCL:
            begin
                if (int'(tid) > rwlm_pkg::THREAD_ID_MAX)
                    r.outcome = rwlm_pkg::OUT_REFUSED;
                else if (lock_count == 0)
                begin
                    lock_count = -1;
                    owner_id   = tid;
                    r.outcome  = rwlm_pkg::OUT_GRANTED;
                end
                else if (lock_count < 0 && owner_id == tid)
                    r.outcome = deepen_writer_depth();
                else if (!may_wait || writers_waiting >= rwlm_pkg::WAITERS_MAX)
                    r.outcome = rwlm_pkg::OUT_REFUSED;
                else
                begin
                    writers_waiting++;
                    r.outcome = rwlm_pkg::OUT_QUEUED;
                end
            end
            rwlm_pkg::OP_ACQ_SHARED:
            begin
                if (int'(tid) > rwlm_pkg::THREAD_ID_MAX)
                    r.outcome = rwlm_pkg::OUT_REFUSED;
                else if (lock_count < 0)
                begin
                    if (owner_id == tid)
                        r.outcome = deepen_writer_depth();
                    else if (may_wait && readers_waiting < rwlm_pkg::READER_Q_LIMIT)
                    begin
                        readers_waiting++;
                        r.outcome = rwlm_pkg::OUT_QUEUED;
                    end
                    else
                        r.outcome = rwlm_pkg::OUT_REFUSED;
                end
                // a woken reader was already counted at wake time
                else if (woken)
                    r.outcome = rwlm_pkg::OUT_GRANTED;
                else if (lock_count >= rwlm_pkg::COUNT_MAX)
                    r.outcome = rwlm_pkg::OUT_REFUSED;
                else
                begin
                    lock_count++;
                    r.outcome = rwlm_pkg::OUT_GRANTED;
                end
            end
            rwlm_pkg::OP_RELEASE:
            begin
                if (lock_count > 0)
                begin
                    lock_count--;
                    if (lock_count == 0 && writers_waiting != 0)
                    begin
                        writers_waiting--;
                        r.wake_writer = 1'b1;
                    end
                    r.outcome = rwlm_pkg::OUT_RELEASED;
                end
                else if (lock_count < 0)
                begin
                    lock_count++;
                    // lock freed: one writer first, else every waiting reader
                    if (lock_count == 0)
                    begin
                        owner_id = '0;
                        if (writers_waiting != 0)
                        begin
                            writers_waiting--;
                            r.wake_writer = 1'b1;
                        end
                        else if (readers_waiting != 0)
                        begin
                            r.wake_readers  = readers_waiting[rwlm_pkg::WAITERS_W-1:0];
                            lock_count      = readers_waiting;
                            readers_waiting = 0;
                        end
                    end
                    r.outcome = rwlm_pkg::OUT_RELEASED;
                end
                else
                    r.outcome = rwlm_pkg::OUT_IGNORED;
            end
            default:
                r.outcome = rwlm_pkg::OUT_REFUSED;
        endcase
        r.active = rwlm_pkg::count_t'(lock_count);
        return r;
    endfunction

    task automatic report_field(string field, int want, int got);
        if (want != got)
        begin
            if (fail_total < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            fail_total++;
        end
    endtask

    // Compare finished results first, then record the request accepted this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        lock_result_t got;
        lock_result_t want;
        if (!rst_n)
        begin
            lock_count      = 0;
            owner_id        = '0;
            writers_waiting = 0;
            readers_waiting = 0;
            fail_total      = 0;
            results_due.delete();
            mismatches      <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.outcome      = rwlm_pkg::outcome_t'(m_tuser);
                got.wake_writer  = m_tdata[0];
                got.wake_readers = m_tdata[8:1];
                got.active       = rwlm_pkg::count_t'(m_tdata[17:9]);
                if (results_due.size() == 0)
                begin
                    if (fail_total < REPORT_LIMIT)
                        $display({"%0t: result with nothing expected, expected none, ",
                                  "actual %0d/%0d/%0d/%0d"},
                                 $time, got.outcome, got.wake_writer, got.wake_readers,
                                 $signed(got.active));
                    fail_total++;
                end
                else
                begin
                    want = results_due.pop_front();
                    report_field("outcome", int'(want.outcome), int'(got.outcome));
                    report_field("wake_writer", int'(want.wake_writer), int'(got.wake_writer));
                    report_field("wake_readers", int'(want.wake_readers), int'(got.wake_readers));
                    report_field("active_count", int'($signed(want.active)),
                                 int'($signed(got.active)));
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(predict_lock_step(rwlm_pkg::op_t'(s_tuser),
                                                        s_tdata[7:0], s_tdata[8],
                                                        s_tdata[9]));
            mismatches      <= fail_total;
            results_pending <= results_due.size();
        end
    end

endmodule

[tb/reader_writer_lock_manager_core_test.sv]
// Testbench top for the lock manager: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module reader_writer_lock_manager_core_test;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int REQUEST_TARGET = 2000;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 500;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic [rwlm_pkg::S_DATA_W-1:0]      s_tdata  = '0;
    logic [rwlm_pkg::S_USER_W-1:0]      s_tuser  = '0;
    logic                               m_tready = 1'b0;
    logic                               s_tready;
    logic                               m_tvalid;
    logic [rwlm_pkg::M_DATA_W-1:0]      m_tdata;
    logic [rwlm_pkg::M_USER_W-1:0]      m_tuser;

    int mismatches;
    int results_pending;
    int cycles        = 0;
    int requests_sent = 0;
    bit tx_no_gaps    = 1'b0;

    always #10 clk = ~clk;

    reader_writer_lock_manager_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rwlm_result_monitor monitor
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // Run length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random ready gaps, no-gap stretches, one long hold-off
    initial
    begin : result_drain
        int gap;
        int taken;
        bit rx_no_gaps;
        taken      = 0;
        rx_no_gaps = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                rx_no_gaps = ($urandom_range(0, 3) == 0);
            gap = rx_no_gaps ? 0 : $urandom_range(0, 11);
            if (taken == HOLD_AT_RESULT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    // One request; valid stays high when the next one follows without a gap
    task automatic send_request(rwlm_pkg::op_t op, logic [rwlm_pkg::TID_W-1:0] tid,
                                logic may_wait, logic woken);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(rwlm_pkg::S_DATA_W-rwlm_pkg::TID_W-2){1'b0}}, woken, may_wait, tid};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    function automatic rwlm_pkg::op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return rwlm_pkg::OP_ACQ_EXCL;
        if (r < 60)
            return rwlm_pkg::OP_ACQ_SHARED;
        if (r < 95)
            return rwlm_pkg::OP_RELEASE;
        return rwlm_pkg::OP_UNUSED;
    endfunction

    // Mostly a small pool of threads so owners meet again
    function automatic logic [rwlm_pkg::TID_W-1:0] pick_tid();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return rwlm_pkg::TID_W'($urandom_range(1, 4));
        if (r < 9)
            return '0;
        return rwlm_pkg::TID_W'($urandom_range(0, 255));
    endfunction

    // Short runs usually, now and then one long enough to hit a counter limit
    function automatic int pick_run_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(250, 262);
        return $urandom_range(1, 12);
    endfunction

    initial
    begin : stimulus
        int kind;
        int n;
        logic [rwlm_pkg::TID_W-1:0] t;
        bit readers_heavy;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: free release, unused op, writer re-entry, refusals, queueing,
        // writer wake, reader wake with woken retries, thread id zero as owner
        send_request(rwlm_pkg::OP_RELEASE,    8'd0,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_UNUSED,     8'd255, 1'b1, 1'b1);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd255, 1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd255, 1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd255, 1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd0,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd1,   1'b1, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd2,   1'b1, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd3,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd4,   1'b1, 1'b1);
        repeat (3) send_request(rwlm_pkg::OP_RELEASE, 8'd255, 1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd1,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_RELEASE,    8'd1,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd2,   1'b0, 1'b1);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd4,   1'b0, 1'b1);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd0,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd5,   1'b1, 1'b0);
        repeat (3) send_request(rwlm_pkg::OP_RELEASE, 8'd7, 1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_EXCL,   8'd0,   1'b0, 1'b0);
        send_request(rwlm_pkg::OP_ACQ_SHARED, 8'd0,   1'b0, 1'b0);
        repeat (2) send_request(rwlm_pkg::OP_RELEASE, 8'd0, 1'b0, 1'b0);

        // Random scenarios until the request budget is spent
        while (requests_sent < REQUEST_TARGET)
        begin
            tx_no_gaps    = ($urandom_range(0, 3) == 0);
            kind          = $urandom_range(0, 9);
            n             = pick_run_len();
            t             = pick_tid();
            readers_heavy = 1'($urandom_range(0, 1));
            if (kind < 5)
            begin
                // free mix, including noise
                repeat ($urandom_range(4, 20))
                    send_request(pick_op(), pick_tid(), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 2) == 0);
            end
            else if (kind < 6)
            begin
                // readers pile up, then drain
                repeat (n)
                    send_request(rwlm_pkg::OP_ACQ_SHARED, pick_tid(),
                                 1'($urandom_range(0, 1)), 1'b0);
                repeat (n + 1) send_request(rwlm_pkg::OP_RELEASE, pick_tid(), 1'b0, 1'b0);
            end
            else if (kind < 7)
            begin
                // one writer re-enters repeatedly, then unwinds
                repeat (n)
                    send_request(rwlm_pkg::op_t'($urandom_range(0, 1) ?
                                                 rwlm_pkg::OP_ACQ_EXCL :
                                                 rwlm_pkg::OP_ACQ_SHARED),
                                 t, 1'($urandom_range(0, 1)), 1'b0);
                repeat (n + 1) send_request(rwlm_pkg::OP_RELEASE, t, 1'b0, 1'b0);
            end
            else
            begin
                // writer holds, others queue, release wakes, woken come back
                send_request(rwlm_pkg::OP_ACQ_EXCL, t, 1'b1, 1'b0);
                repeat (n)
                    send_request(rwlm_pkg::op_t'(($urandom_range(0, 9) <
                                                  (readers_heavy ? 8 : 2)) ?
                                                 rwlm_pkg::OP_ACQ_SHARED :
                                                 rwlm_pkg::OP_ACQ_EXCL),
                                 pick_tid(), $urandom_range(0, 7) != 0, 1'b0);
                send_request(rwlm_pkg::OP_RELEASE, t, 1'b0, 1'b0);
                send_request(rwlm_pkg::OP_ACQ_EXCL, pick_tid(), 1'b1, 1'b0);
                send_request(rwlm_pkg::OP_RELEASE, pick_tid(), 1'b0, 1'b0);
                repeat (n)
                    send_request(rwlm_pkg::OP_ACQ_SHARED, pick_tid(),
                                 1'($urandom_range(0, 1)), 1'b1);
                repeat (n) send_request(rwlm_pkg::OP_RELEASE, pick_tid(), 1'b0, 1'b0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
